### rtl/core/assert_macros.svh
// assertion macros for the rtl files
// empty bodies when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

### rtl/core/blme_pkg.sv
// types and constants of the bounded list with match erase
// no dependencies
package blme_pkg;

  localparam int unsigned Depth = 64;
  localparam int unsigned AddrW = 6;
  localparam int unsigned CntW  = 7;
  localparam int unsigned DataW = 32;
  localparam int unsigned AnsW  = 32;

  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

  typedef enum logic [2:0] {
    KindPushFront = 3'd0,
    KindPushBack  = 3'd1,
    KindPopFront  = 3'd2,
    KindErase     = 3'd3,
    KindCount     = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    StatusOk    = 2'd0,
    StatusEmpty = 2'd1,
    StatusFull  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    StIdle,
    StPop,
    StWalk
  } state_e;

  typedef struct packed {
    kind_e             kind;
    logic [DataW-1:0]  value;
  } req_t;

  typedef struct packed {
    logic [AnsW-1:0]   answer;
    status_e           status;
    logic [DataW-1:0]  front_value;
    logic [DataW-1:0]  back_value;
    logic [CntW-1:0]   length;
    logic              is_empty;
  } rsp_t;

endpackage

### rtl/core/bounded_list_with_match_erase_top.sv
// bounded ordered list kept in a circular buffer memory with one read and one write port
// depends on blme_pkg and assert_macros.svh
//
// usage:
//   an item (kind, value) is taken on req_i at a rising edge with start high and busy low
//   every item gives one result on rsp_o, shown for one cycle with done_o high
//   push front, push back, full push, empty pop and unused kinds: result in the cycle
//   after the item, next item may follow at once (one item per cycle)
//   pop front: the new front is read back from the memory into the read register, and
//   the pop state then registers the result; busy high for one cycle
//   erase and count: the memory read port walks the stored entries one per cycle,
//   busy stays high until the walk has passed every stored entry, and the result is
//   registered when the walk ends; no new item is taken during the walk
//   erase writes the kept entries back in place behind the read pointer
//   reset empties the list at once; the memory itself is not cleared
//   the receiver cannot stall: each result is taken in the cycle it is shown
`include "assert_macros.svh"

module bounded_list_with_match_erase_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  blme_pkg::req_t req_i,
  output logic           busy,
  output logic           done_o,
  output blme_pkg::rsp_t rsp_o
);
  import blme_pkg::*;

  state_e            state_q, state_d;
  logic [AddrW-1:0]  first_q, first_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [CntW-1:0]   kept_q, kept_d;
  logic [CntW-1:0]   rd_idx_q, rd_idx_d;
  logic [CntW-1:0]   hits_q, hits_d;
  logic              vld_q, vld_d;
  logic              erase_q, erase_d;
  logic [DataW-1:0]  key_q, key_d;
  logic [DataW-1:0]  front_q, front_d;
  logic [DataW-1:0]  back_q, back_d;
  logic              done_q, done_d;
  rsp_t              rsp_q, rsp_d;

  logic [DataW-1:0]  mem [Depth];
  logic [DataW-1:0]  rd_data_q;
  logic              we, re;
  logic [AddrW-1:0]  wa, ra;
  logic [DataW-1:0]  wd;

  logic              accept;
  logic              walk_end;
  logic              match;
  status_e           status_d;
  logic [AnsW-1:0]   ans_d;

  assign busy     = (state_q != StIdle);
  assign accept   = start && !busy;
  assign walk_end = (rd_idx_q == count_q);
  assign match    = (rd_data_q == key_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if (req_i.kind == KindPopFront && count_q != '0) begin
            state_d = StPop;
          end else if (req_i.kind == KindErase || req_i.kind == KindCount) begin
            state_d = StWalk;
          end
        end
      end
      StPop: begin
        state_d = StIdle;
      end
      StWalk: begin
        if (walk_end) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // datapath and memory control
  always_comb begin
    first_d  = first_q;
    count_d  = count_q;
    kept_d   = kept_q;
    rd_idx_d = rd_idx_q;
    hits_d   = hits_q;
    vld_d    = 1'b0;
    erase_d  = erase_q;
    key_d    = key_q;
    front_d  = front_q;
    back_d   = back_q;
    done_d   = 1'b0;
    status_d = StatusOk;
    ans_d    = '0;
    we       = 1'b0;
    re       = 1'b0;
    wa       = first_q + kept_q[AddrW-1:0];
    wd       = rd_data_q;
    ra       = first_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          unique case (req_i.kind)
            KindPushFront, KindPushBack: begin
              done_d = 1'b1;
              if (count_q == DepthCnt) begin
                status_d = StatusFull;
              end else begin
                we      = 1'b1;
                wd      = req_i.value;
                count_d = count_q + CntW'(1);
                if (req_i.kind == KindPushFront) begin
                  wa      = first_q - AddrW'(1);
                  first_d = first_q - AddrW'(1);
                  front_d = req_i.value;
                  if (count_q == '0) begin
                    back_d = req_i.value;
                  end
                end else begin
                  wa     = first_q + count_q[AddrW-1:0];
                  back_d = req_i.value;
                  if (count_q == '0) begin
                    front_d = req_i.value;
                  end
                end
              end
            end
            KindPopFront: begin
              if (count_q == '0) begin
                done_d   = 1'b1;
                status_d = StatusEmpty;
              end else begin
                re      = 1'b1;
                ra      = first_q + AddrW'(1);
                first_d = first_q + AddrW'(1);
                count_d = count_q - CntW'(1);
                key_d   = front_q;
              end
            end
            KindErase, KindCount: begin
              erase_d  = (req_i.kind == KindErase);
              key_d    = req_i.value;
              rd_idx_d = '0;
              kept_d   = '0;
              hits_d   = '0;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      StPop: begin
        done_d  = 1'b1;
        ans_d   = key_q;
        front_d = rd_data_q;
      end
      StWalk: begin
        if (!walk_end) begin
          re       = 1'b1;
          ra       = first_q + rd_idx_q[AddrW-1:0];
          rd_idx_d = rd_idx_q + CntW'(1);
          vld_d    = 1'b1;
        end
        if (vld_q) begin
          if (match) begin
            hits_d = hits_q + CntW'(1);
          end else begin
            kept_d = kept_q + CntW'(1);
            if (erase_q) begin
              we     = 1'b1;
              back_d = rd_data_q;
              if (kept_q == '0) begin
                front_d = rd_data_q;
              end
            end
          end
        end
        if (walk_end) begin
          done_d = 1'b1;
          ans_d  = AnsW'(hits_d);
          if (erase_q) begin
            count_d = kept_d;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    rsp_d.answer      = ans_d;
    rsp_d.status      = status_d;
    rsp_d.length      = count_d;
    rsp_d.is_empty    = (count_d == '0);
    rsp_d.front_value = rsp_d.is_empty ? '0 : front_d;
    rsp_d.back_value  = rsp_d.is_empty ? '0 : back_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      first_q  <= '0;
      count_q  <= '0;
      kept_q   <= '0;
      rd_idx_q <= '0;
      hits_q   <= '0;
      vld_q    <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      first_q  <= first_d;
      count_q  <= count_d;
      kept_q   <= kept_d;
      rd_idx_q <= rd_idx_d;
      hits_q   <= hits_d;
      vld_q    <= vld_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    erase_q <= erase_d;
    key_q   <= key_d;
    front_q <= front_d;
    back_q  <= back_d;
    if (done_d) begin
      rsp_q <= rsp_d;
    end
  end

  // entry memory
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_data_q <= mem[ra];
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  `ASSERT_NEVER(a_count_range, clk_i, rst_ni, count_q > DepthCnt, "stored count above depth")
  `ASSERT_PROP(a_done_idle, clk_i, rst_ni, done_q |-> state_q == StIdle, "result while busy")
  `ASSERT_NEVER(a_rw_clash, clk_i, rst_ni, we && re && (wa == ra), "write hits unread entry")
  `ASSERT_PROP(a_kept_order, clk_i, rst_ni, state_q == StWalk |-> kept_q <= rd_idx_q, "write ahead of read")
  `ASSERT_PROP(a_push_quick, clk_i, rst_ni, (accept && (req_i.kind == KindPushFront || req_i.kind == KindPushBack)) |=> done_q, "push result late")

endmodule
